FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/rns_pkg.sv
package rns_pkg;

  // Squared distances are kept at a fixed width and saturate.
  localparam int unsigned DIST_W = 34;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // At most this many neighbors are reported per query.
  localparam int unsigned RESULT_CAP = 32;
  localparam int unsigned CAP_W = 6;
  localparam int unsigned IDX_OUT_W = 5;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef logic [DIST_W-1:0] dist_t;

endpackage

FILE: rtl/rns_dist.sv
module rns_dist #(
  parameter int unsigned CoordBits = 16,
  parameter int unsigned IdxBits   = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [CoordBits-1:0] ax_i,
  input  logic signed [CoordBits-1:0] ay_i,
  input  logic signed [CoordBits-1:0] bx_i,
  input  logic signed [CoordBits-1:0] by_i,
  input  logic        [IdxBits-1:0]   idx_i,
  output logic                        valid_o,
  output rns_pkg::dist_t              dist_o,
  output logic        [IdxBits-1:0]   idx_o
);
  import rns_pkg::*;

  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned SQW = 2 * DW;
  localparam int unsigned SW = SQW + 1;

  logic signed [DW-1:0] ex_ax, ex_ay, ex_bx, ex_by, sdx, sdy;
  logic [DW-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [SQW-1:0] sqx_q, sqy_q;
  logic [SW-1:0] sum;
  logic [SW+DIST_W-1:0] sum_w, max_w;
  logic [2:0] v_q;
  logic [IdxBits-1:0] i1_q, i2_q;
  dist_t dist_q;

  // Absolute coordinate differences.
  always_comb begin
    ex_ax = DW'(ax_i);
    ex_ay = DW'(ay_i);
    ex_bx = DW'(bx_i);
    ex_by = DW'(by_i);
    sdx = (ex_ax >= ex_bx) ? ex_ax - ex_bx : ex_bx - ex_ax;
    sdy = (ex_ay >= ex_by) ? ex_ay - ex_by : ex_by - ex_ay;
    dx_d = sdx;
    dy_d = sdy;
  end

  // Sum of squares with saturation.
  assign sum = SW'(sqx_q) + SW'(sqy_q);
  assign sum_w = {{DIST_W{1'b0}}, sum};
  assign max_w = {{SW{1'b0}}, DIST_MAX};

  // Three-stage pipeline: difference, square, sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
    i1_q <= idx_i;
    sqx_q <= dx_q * dx_q;
    sqy_q <= dy_q * dy_q;
    i2_q <= i1_q;
    dist_q <= (sum_w > max_w) ? DIST_MAX : sum_w[DIST_W-1:0];
    idx_o <= i2_q;
  end

  assign valid_o = v_q[2];
  assign dist_o = dist_q;

endmodule

FILE: rtl/radius_neighbor_search_sorted_core.sv
// Fixed-radius neighbor search over a store of 2D points.
// Input: a word is taken when start_i is high and busy_o is low. opcode_i
// selects clear, load or query; point_x_i/point_y_i carry the point.
// Config: radius_we_i writes radius_squared_i; write it only while idle.
// Output: every result word is shown for one cycle with result_valid_o high,
// and last_o marks the final word of an input. The receiver cannot stall.
// Clear and load answer with one word in the cycle after acceptance and
// keep busy_o low. Opcode 3 is dropped with no answer.
// A query with N stored points first runs all points through the distance
// pipeline, then for each of K reported neighbors does one selection scan
// over the distance memory plus a point read. A query with no neighbor
// answers with one empty word. At most 32 nearest neighbors are reported.
// Reset empties the store and sets the radius to zero; memories need no
// clearing since entries beyond the fill count are never read.
module radius_neighbor_search_sorted_core #(
  parameter int unsigned MAX_POINTS = 32,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   opcode_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic                         radius_we_i,
  input  rns_pkg::dist_t               radius_squared_i,
  output logic                         result_valid_o,
  output logic signed [COORD_BITS-1:0] neighbor_x_o,
  output logic signed [COORD_BITS-1:0] neighbor_y_o,
  output logic [rns_pkg::IDX_OUT_W-1:0] neighbor_index_o,
  output rns_pkg::dist_t               distance_squared_o,
  output logic                         found_o,
  output logic                         load_rejected_o,
  output logic                         last_o
);
  import rns_pkg::*;

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned PW = 2 * COORD_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_SEL, ST_READ, ST_EMIT
  } state_e;

  state_e state_q;
  logic [CW-1:0] count_q, rd_q, done_q, nbr_q;
  logic [CAP_W-1:0] total_q, emitted_q;
  logic signed [COORD_BITS-1:0] ref_x_q, ref_y_q;
  dist_t radius_q;
  logic first_q, have_q;
  dist_t best_d_q, prev_d_q;
  logic [IW-1:0] best_i_q, prev_i_q;
  logic scan_v_q, sel_v_q;
  logic [IW-1:0] scan_i_q, sel_i_q;

  // Memories.
  logic [PW-1:0] pt_mem [MAX_POINTS];
  logic [PW-1:0] pt_rdata_q;
  logic [IW-1:0] pt_raddr;
  logic [DIST_W:0] dm_mem [MAX_POINTS];
  logic [DIST_W:0] dm_rdata_q;

  // Distance pipeline.
  logic du_valid;
  dist_t du_dist;
  logic [IW-1:0] du_idx;
  logic du_within;

  // Selection signals.
  logic sel_within, sel_elig;
  dist_t sel_d;
  logic [CW+CAP_W-1:0] nbr_w;
  logic [IW+IDX_OUT_W-1:0] best_i_w;

  rns_dist #(
    .CoordBits(COORD_BITS),
    .IdxBits  (IW)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(scan_v_q),
    .ax_i   (pt_rdata_q[PW-1:COORD_BITS]),
    .ay_i   (pt_rdata_q[COORD_BITS-1:0]),
    .bx_i   (ref_x_q),
    .by_i   (ref_y_q),
    .idx_i  (scan_i_q),
    .valid_o(du_valid),
    .dist_o (du_dist),
    .idx_o  (du_idx)
  );

  assign du_within = (du_dist <= radius_q);
  assign busy_o = (state_q != ST_IDLE);

  // Point memory read address by phase.
  always_comb begin
    unique case (state_q)
      ST_READ: pt_raddr = best_i_q;
      default: pt_raddr = rd_q[IW-1:0];
    endcase
  end

  // Point memory: written on load, read during scan and emit.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i && opcode_e'(opcode_i) == OP_LOAD &&
        count_q < CW'(MAX_POINTS)) begin
      pt_mem[count_q[IW-1:0]] <= {point_x_i, point_y_i};
    end
    pt_rdata_q <= pt_mem[pt_raddr];
  end

  // Distance memory: written by the distance pipeline, read by selection.
  always_ff @(posedge clk_i) begin
    if (du_valid) begin
      dm_mem[du_idx] <= {du_within, du_dist};
    end
    dm_rdata_q <= dm_mem[rd_q[IW-1:0]];
  end

  // A candidate must be in range and rank after the previously reported one.
  assign sel_within = dm_rdata_q[DIST_W];
  assign sel_d = dm_rdata_q[DIST_W-1:0];
  assign sel_elig = sel_within && (first_q || (sel_d > prev_d_q) ||
                    (sel_d == prev_d_q && sel_i_q > prev_i_q));
  assign nbr_w = {{CAP_W{1'b0}}, nbr_q};
  assign best_i_w = {{IDX_OUT_W{1'b0}}, best_i_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      radius_q <= '0;
      rd_q <= '0;
      done_q <= '0;
      nbr_q <= '0;
      total_q <= '0;
      emitted_q <= '0;
      first_q <= 1'b0;
      have_q <= 1'b0;
      scan_v_q <= 1'b0;
      sel_v_q <= 1'b0;
      result_valid_o <= 1'b0;
      ref_x_q <= '0;
      ref_y_q <= '0;
    end else begin
      result_valid_o <= 1'b0;
      scan_v_q <= 1'b0;
      sel_v_q <= 1'b0;
      if (radius_we_i) begin
        radius_q <= radius_squared_i;
      end
      unique case (state_q)
        // Take a word; clear and load are answered right away.
        ST_IDLE: begin
          if (start_i) begin
            neighbor_x_o <= '0;
            neighbor_y_o <= '0;
            neighbor_index_o <= '0;
            distance_squared_o <= '0;
            found_o <= 1'b0;
            load_rejected_o <= 1'b0;
            last_o <= 1'b1;
            unique case (opcode_e'(opcode_i))
              OP_CLEAR: begin
                count_q <= '0;
                result_valid_o <= 1'b1;
              end
              OP_LOAD: begin
                result_valid_o <= 1'b1;
                if (count_q < CW'(MAX_POINTS)) begin
                  count_q <= count_q + 1'b1;
                end else begin
                  load_rejected_o <= 1'b1;
                end
              end
              OP_QUERY: begin
                ref_x_q <= point_x_i;
                ref_y_q <= point_y_i;
                rd_q <= '0;
                done_q <= '0;
                nbr_q <= '0;
                state_q <= ST_SCAN;
              end
              OP_NONE: begin
                result_valid_o <= 1'b0;
              end
            endcase
          end
        end
        // Feed every stored point through the distance pipeline.
        ST_SCAN: begin
          if (rd_q < count_q) begin
            scan_v_q <= 1'b1;
            scan_i_q <= rd_q[IW-1:0];
            rd_q <= rd_q + 1'b1;
          end
          if (du_valid) begin
            done_q <= done_q + 1'b1;
            if (du_within) begin
              nbr_q <= nbr_q + 1'b1;
            end
          end else if (done_q == count_q) begin
            rd_q <= '0;
            if (nbr_q == '0) begin
              result_valid_o <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              total_q <= (nbr_w > (CW+CAP_W)'(RESULT_CAP)) ? CAP_W'(RESULT_CAP)
                                                          : nbr_w[CAP_W-1:0];
              emitted_q <= '0;
              first_q <= 1'b1;
              have_q <= 1'b0;
              state_q <= ST_SEL;
            end
          end
        end
        // Scan the distance memory for the next nearest neighbor.
        ST_SEL: begin
          if (rd_q < count_q) begin
            sel_v_q <= 1'b1;
            sel_i_q <= rd_q[IW-1:0];
            rd_q <= rd_q + 1'b1;
          end
          if (sel_v_q) begin
            if (sel_elig && (!have_q || sel_d < best_d_q)) begin
              have_q <= 1'b1;
              best_d_q <= sel_d;
              best_i_q <= sel_i_q;
            end
          end else if (rd_q == count_q) begin
            state_q <= ST_READ;
          end
        end
        // Fetch the chosen point.
        ST_READ: begin
          state_q <= ST_EMIT;
        end
        // Send the neighbor and move on.
        ST_EMIT: begin
          result_valid_o <= 1'b1;
          neighbor_x_o <= pt_rdata_q[PW-1:COORD_BITS];
          neighbor_y_o <= pt_rdata_q[COORD_BITS-1:0];
          neighbor_index_o <= best_i_w[IDX_OUT_W-1:0];
          distance_squared_o <= best_d_q;
          found_o <= 1'b1;
          load_rejected_o <= 1'b0;
          last_o <= (emitted_q + 1'b1 == total_q);
          emitted_q <= emitted_q + 1'b1;
          prev_d_q <= best_d_q;
          prev_i_q <= best_i_q;
          first_q <= 1'b0;
          have_q <= 1'b0;
          rd_q <= '0;
          state_q <= (emitted_q + 1'b1 == total_q) ? ST_IDLE : ST_SEL;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CW'(MAX_POINTS), "store overfilled")
  `ASSERT_NEVER(a_found_rej, clk_i, rst_ni, result_valid_o && found_o && load_rejected_o, "found with reject")
  `ASSERT_CLK(a_in_radius, clk_i, rst_ni, !(result_valid_o && found_o) || distance_squared_o <= radius_q, "neighbor outside radius")
  `ASSERT_CLK(a_emit_have, clk_i, rst_ni, !(state_q == ST_READ) || have_q, "no neighbor selected")

endmodule

FILE: tb/radius_neighbor_search_sorted_core_tb.sv
`timescale 1ns / 1ps

module radius_neighbor_search_sorted_core_tb;
  import rns_pkg::*;

  localparam int unsigned NPTS = 32;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic [4:0]         nidx;
    dist_t              dsq;
    logic               found;
    logic               rejected;
    logic               last;
  } neighbor_word_t;

  // Scoreboard: holds the store copy and the queue of expected result words.
  class neighbor_scoreboard;
    logic signed [15:0] px[NPTS];
    logic signed [15:0] py[NPTS];
    int unsigned        fill;
    dist_t              radius;
    neighbor_word_t     pending[$];
    int unsigned        mismatches;

    function new();
      fill = 0;
      radius = '0;
      mismatches = 0;
    endfunction

    function dist_t sq_dist(logic signed [15:0] ax, logic signed [15:0] ay,
                            logic signed [15:0] bx, logic signed [15:0] by);
      longint dx;
      longint dy;
      longint s;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      s = dx * dx + dy * dy;
      if (s > longint'(DIST_MAX)) return DIST_MAX;
      return dist_t'(s);
    endfunction

    // Append one expected word at the tail of the queue.
    function void add_expected(neighbor_word_t w);
      pending.insert(pending.size(), w);
    endfunction

    function void push_ack(logic rej);
      neighbor_word_t w;
      w = '{16'sd0, 16'sd0, 5'd0, '0, 1'b0, rej, 1'b1};
      add_expected(w);
    endfunction

    // Note an accepted input word and queue the words it causes.
    function void note_input(opcode_e op, logic signed [15:0] x, logic signed [15:0] y);
      int unsigned sidx[$];
      dist_t sd[$];
      dist_t d;
      int pos;
      int emit;
      neighbor_word_t w;
      case (op)
        OP_CLEAR: begin
          fill = 0;
          push_ack(1'b0);
        end
        OP_LOAD: begin
          if (fill >= NPTS) begin
            push_ack(1'b1);
          end else begin
            px[fill] = x;
            py[fill] = y;
            fill++;
            push_ack(1'b0);
          end
        end
        OP_QUERY: begin
          for (int i = 0; i < fill; i++) begin
            d = sq_dist(x, y, px[i], py[i]);
            if (d <= radius) begin
              pos = sd.size();
              while (pos > 0 && sd[pos-1] > d) pos--;
              sd.insert(pos, d);
              sidx.insert(pos, i);
            end
          end
          if (sd.size() == 0) begin
            push_ack(1'b0);
          end else begin
            emit = (sd.size() > RESULT_CAP) ? RESULT_CAP : sd.size();
            for (int i = 0; i < emit; i++) begin
              w.nx = px[sidx[i]];
              w.ny = py[sidx[i]];
              w.nidx = sidx[i][4:0];
              w.dsq = sd[i];
              w.found = 1'b1;
              w.rejected = 1'b0;
              w.last = (i == emit - 1);
              add_expected(w);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result word against the oldest expectation.
    function void check_result(neighbor_word_t got);
      neighbor_word_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: idx %0d dist %0d",
                                       got.nidx, got.dsq);
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp x %0d y %0d i %0d d %0d f %0b r %0b l %0b",
                   exp_w.nx, exp_w.ny, exp_w.nidx, exp_w.dsq, exp_w.found,
                   exp_w.rejected, exp_w.last);
          $display("          got x %0d y %0d i %0d d %0d f %0b r %0b l %0b",
                   got.nx, got.ny, got.nidx, got.dsq, got.found, got.rejected,
                   got.last);
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [1:0]         opcode_i;
  logic signed [15:0] point_x_i;
  logic signed [15:0] point_y_i;
  logic               radius_we_i;
  dist_t              radius_squared_i;
  logic               result_valid_o;
  logic signed [15:0] neighbor_x_o;
  logic signed [15:0] neighbor_y_o;
  logic [4:0]         neighbor_index_o;
  dist_t              distance_squared_o;
  logic               found_o;
  logic               load_rejected_o;
  logic               last_o;

  neighbor_scoreboard sb;
  int unsigned        cycles;
  bit                 no_idle;

  radius_neighbor_search_sorted_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .point_x_i, .point_y_i,
    .radius_we_i, .radius_squared_i, .result_valid_o, .neighbor_x_o,
    .neighbor_y_o, .neighbor_index_o, .distance_squared_o, .found_o,
    .load_rejected_o, .last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample result words at the rising edge.
  always @(posedge clk_i) begin
    neighbor_word_t w;
    if (rst_ni && result_valid_o) begin
      w = '{neighbor_x_o, neighbor_y_o, neighbor_index_o, distance_squared_o,
            found_o, load_rejected_o, last_o};
      sb.check_result(w);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("radius_neighbor_search_sorted_core_tb: FAIL");
      $finish;
    end
  end

  // Send one input word and hold start until it is taken. Start stays high
  // on return; the next word or a drain takes it down at this same edge.
  task automatic send_word(opcode_e op, logic signed [15:0] x, logic signed [15:0] y);
    while (!no_idle && $urandom_range(99) < 19) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    point_x_i <= x;
    point_y_i <= y;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_input(op, x, y);
    @(negedge clk_i);
  endtask

  // Wait until every expected word has come, plus a settling gap.
  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (1200) @(negedge clk_i);
  endtask

  // Radius writes happen only while the block is idle.
  task automatic write_radius(dist_t r);
    drain();
    radius_we_i <= 1'b1;
    radius_squared_i <= r;
    @(negedge clk_i);
    radius_we_i <= 1'b0;
    radius_squared_i <= dist_t'({$urandom, $urandom});
    sb.radius = r;
  endtask

  function automatic logic signed [15:0] rand_coord(int span);
    if (span >= 32768 || $urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(2 * span) - span);
  endfunction

  initial begin
    dist_t radii[6];
    int span;
    sb = new();
    cycles = 0;
    no_idle = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    opcode_i = OP_CLEAR;
    point_x_i = '0;
    point_y_i = '0;
    radius_we_i = 1'b0;
    radius_squared_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty store query, extremes, ties, overflow, full store.
    send_word(OP_QUERY, 16'sd0, 16'sd0);
    send_word(OP_LOAD, 16'sh8000, 16'sh8000);
    send_word(OP_LOAD, 16'sh7fff, 16'sh7fff);
    send_word(OP_LOAD, 16'sd0, 16'sd0);
    send_word(OP_QUERY, 16'sd0, 16'sd0);
    write_radius(DIST_MAX);
    send_word(OP_QUERY, 16'sh8000, 16'sh8000);
    send_word(OP_NONE, 16'sd5, 16'sd5);
    send_word(OP_LOAD, 16'sd3, 16'sd4);
    send_word(OP_LOAD, -16'sd3, 16'sd4);
    send_word(OP_QUERY, 16'sd0, 16'sd0);
    send_word(OP_CLEAR, 16'sd0, 16'sd0);
    for (int i = 0; i < 33; i++) send_word(OP_LOAD, 16'(i), -16'(i));
    send_word(OP_QUERY, 16'sd1, 16'sd1);
    write_radius(dist_t'(8));
    send_word(OP_QUERY, 16'sd4, -16'sd4);
    write_radius('0);
    send_word(OP_QUERY, 16'sd4, -16'sd4);

    // Random phases with varied radius and coordinate spans.
    radii = '{dist_t'(0), dist_t'(100), dist_t'(20000), dist_t'(2000000),
              DIST_MAX, dist_t'({$urandom, $urandom})};
    for (int ph = 0; ph < 12; ph++) begin
      write_radius(radii[ph % 6]);
      span = (ph % 3 == 0) ? 32768 : ((ph % 3 == 1) ? 100 : 2000);
      no_idle = (ph == 5);
      send_word(OP_CLEAR, rand_coord(span), rand_coord(span));
      for (int k = 0; k < 27; k++) begin
        int r;
        r = $urandom_range(99);
        if (r < 55) send_word(OP_LOAD, rand_coord(span), rand_coord(span));
        else if (r < 90) send_word(OP_QUERY, rand_coord(span), rand_coord(span));
        else if (r < 95) send_word(OP_CLEAR, rand_coord(span), rand_coord(span));
        else send_word(OP_NONE, rand_coord(span), rand_coord(span));
        if (k == 15 && ph == 2) drain();
      end
    end
    no_idle = 0;

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("radius_neighbor_search_sorted_core_tb: PASS");
    end else begin
      $display("radius_neighbor_search_sorted_core_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: radius_neighbor_search_sorted_core.f
+incdir+rtl
rtl/rns_pkg.sv
rtl/rns_dist.sv
rtl/radius_neighbor_search_sorted_core.sv
tb/radius_neighbor_search_sorted_core_tb.sv
